>>> hdl/rds_pkg.sv
// Shared types and constants for the RPN data stack.
`default_nettype none

package rds_pkg;

  // Defaults for the top level parameters
  localparam int DEPTH_DEF = 16;
  localparam int WIDTH_DEF = 32;

  // Fixed field widths on the ports
  localparam int OP_W      = 3;
  localparam int VAL_W     = 32;
  localparam int LVL_W     = 5;
  localparam int CNT_OUT_W = 5;
  localparam int STAT_W    = 2;

  // Operands needed by swap and over
  localparam int PAIR_NEEDED = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH,
    OP_DROP,
    OP_DUP,
    OP_SWAP,
    OP_OVER,
    OP_PICK,
    OP_ROLL,
    OP_ROLL_DOWN
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE,
    ST_IGNORED,
    ST_OVERFLOW
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SWAP,
    S_COPY,
    S_HOLD,
    S_MOVE,
    S_PLACE,
    S_WAIT
  } state_t;

endpackage

`default_nettype wire

>>> hdl/rds_ram.sv
// Generic single write, single read RAM with registered, read-first read data.
`default_nettype none

module rds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word when the same address is written in that cycle
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rpn_data_stack.sv
// RPN data stack: push, drop, dup, swap, over, pick, roll, roll down on a RAM-held stack.
// Push, dup, drop to empty and every ignored/refused op need no RAM read; drop, swap, over
// and pick do one RAM read. Roll at level L>=2 first loads its bottom word into a holding
// register, roll down holds the top word: the single RAM port pair moves one word per cycle.
// Reset clears the count, the cached top word, the sequencer and the result valid flag;
// the cell RAM is not cleared and only its words below the count are used.
`default_nettype none

module rpn_data_stack #(
  parameter int STACK_DEPTH = rds_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH  = rds_pkg::WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [rds_pkg::OP_W-1:0]       in_operation,
  input  wire logic [rds_pkg::VAL_W-1:0]      in_push_value,
  input  wire logic [rds_pkg::LVL_W-1:0]      in_level,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [rds_pkg::VAL_W-1:0]      out_top_word,
  output logic      [rds_pkg::CNT_OUT_W-1:0]  out_entry_count,
  output logic      [rds_pkg::STAT_W-1:0]     out_status
);

  import rds_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int LW = (CW > LVL_W) ? CW : LVL_W;

  state_t                st_r, st_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [WORD_WIDTH-1:0] top_r, top_nxt;
  stat_t                 stat_r, stat_nxt;
  logic [WORD_WIDTH-1:0] held_r, held_nxt;
  logic [AW-1:0]         rd_r, rd_nxt;
  logic [AW-1:0]         wr_r, wr_nxt;
  logic [CW-1:0]         rem_r, rem_nxt;
  logic                  up_r, up_nxt;

  logic                  out_valid_r;
  logic [VAL_W-1:0]      out_top_r;
  logic [CNT_OUT_W-1:0]  out_cnt_r;
  stat_t                 out_stat_r;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [WORD_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [WORD_WIDTH-1:0] mem_rdata;

  // decode of the offered item
  op_t                   op;
  logic                  acc;
  logic                  slot_free;
  logic                  full;
  logic                  empty;
  logic [LW-1:0]         lvl_w;
  logic [LW-1:0]         copy_lvl;
  logic                  lvl_ok;
  logic                  copy_ok;
  logic                  lvl_gt1;
  stat_t                 acc_stat;
  logic                  acc_multi;
  logic [AW-1:0]         base_a;
  logic [AW-1:0]         cnt_a;
  logic [AW-1:0]         cnt_m1_a;
  logic [AW-1:0]         cnt_m2_a;
  logic [WORD_WIDTH-1:0] value_w;
  logic                  done;

  rds_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready        = (st_r == S_IDLE);
  assign acc             = in_valid && in_ready;
  assign slot_free       = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_top_word    = out_top_r;
  assign out_entry_count = out_cnt_r;
  assign out_status      = out_stat_r;

  always_comb begin
    op       = op_t'(in_operation);
    full     = (cnt_r == CW'(STACK_DEPTH));
    empty    = (cnt_r == '0);
    lvl_w    = LW'(in_level);
    value_w  = WORD_WIDTH'(in_push_value);
    cnt_a    = AW'(cnt_r);
    cnt_m1_a = AW'(cnt_r - CW'(1));
    cnt_m2_a = AW'(cnt_r - CW'(2));
    base_a   = AW'(LW'(cnt_r) - lvl_w);
    lvl_ok   = (lvl_w != '0) && (lvl_w <= LW'(cnt_r));
    lvl_gt1  = (lvl_w > LW'(1));
    case (op)
      OP_DUP:  copy_lvl = LW'(1);
      OP_OVER: copy_lvl = LW'(PAIR_NEEDED);
      default: copy_lvl = lvl_w;
    endcase
    copy_ok = (copy_lvl != '0) && (copy_lvl <= LW'(cnt_r));

    acc_stat  = ST_DONE;
    acc_multi = 1'b0;
    case (op)
      OP_PUSH: begin
        if (full) acc_stat = ST_OVERFLOW;
      end
      OP_DROP: begin
        if (empty) acc_stat = ST_IGNORED;
        acc_multi = (cnt_r >= CW'(PAIR_NEEDED));
      end
      OP_DUP: begin
        if (!copy_ok) acc_stat = ST_IGNORED;
        else if (full) acc_stat = ST_OVERFLOW;
      end
      OP_SWAP: begin
        if (cnt_r < CW'(PAIR_NEEDED)) acc_stat = ST_IGNORED;
        acc_multi = 1'b1;
      end
      OP_OVER, OP_PICK: begin
        if (!copy_ok) acc_stat = ST_IGNORED;
        else if (full) acc_stat = ST_OVERFLOW;
        acc_multi = 1'b1;
      end
      OP_ROLL, OP_ROLL_DOWN: begin
        if (!lvl_ok) acc_stat = ST_IGNORED;
        acc_multi = lvl_gt1;
      end
      default: begin
        acc_stat = ST_IGNORED;
      end
    endcase
    if (acc_stat != ST_DONE) acc_multi = 1'b0;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (acc) begin
          if (!acc_multi) begin
            st_nxt = slot_free ? S_IDLE : S_WAIT;
          end else begin
            case (op)
              OP_DROP:          st_nxt = S_LOAD;
              OP_SWAP:          st_nxt = S_SWAP;
              OP_OVER, OP_PICK: st_nxt = S_COPY;
              OP_ROLL:          st_nxt = S_HOLD;
              OP_ROLL_DOWN:     st_nxt = S_MOVE;
              default:          st_nxt = S_WAIT;
            endcase
          end
        end
      end
      S_LOAD, S_SWAP, S_COPY, S_PLACE, S_WAIT: begin
        st_nxt = slot_free ? S_IDLE : S_WAIT;
      end
      S_HOLD: begin
        st_nxt = S_MOVE;
      end
      S_MOVE: begin
        if (rem_r == '0) st_nxt = S_PLACE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and RAM control
  always_comb begin
    cnt_nxt   = cnt_r;
    top_nxt   = top_r;
    stat_nxt  = stat_r;
    held_nxt  = held_r;
    rd_nxt    = rd_r;
    wr_nxt    = wr_r;
    rem_nxt   = rem_r;
    up_nxt    = up_r;
    mem_we    = 1'b0;
    mem_waddr = wr_r;
    mem_wdata = mem_rdata;
    mem_raddr = rd_r;
    done      = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (acc) begin
          stat_nxt = acc_stat;
          done     = !acc_multi;
          if (acc_stat == ST_DONE) begin
            case (op)
              OP_PUSH: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_a;
                mem_wdata = value_w;
                top_nxt   = value_w;
                cnt_nxt   = cnt_r + CW'(1);
              end
              OP_DROP: begin
                cnt_nxt   = cnt_r - CW'(1);
                mem_raddr = cnt_m2_a;
                if (!acc_multi) top_nxt = '0;
              end
              OP_DUP: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_a;
                mem_wdata = top_r;
                cnt_nxt   = cnt_r + CW'(1);
              end
              OP_SWAP: begin
                // read-first RAM: old second word comes back next cycle
                mem_raddr = cnt_m2_a;
                mem_we    = 1'b1;
                mem_waddr = cnt_m2_a;
                mem_wdata = top_r;
              end
              OP_OVER, OP_PICK: begin
                mem_raddr = AW'(LW'(cnt_r) - copy_lvl);
              end
              OP_ROLL: begin
                mem_raddr = base_a;
                rd_nxt    = base_a + AW'(1);
                wr_nxt    = base_a;
                rem_nxt   = CW'(lvl_w - LW'(2));
                up_nxt    = 1'b1;
              end
              OP_ROLL_DOWN: begin
                mem_raddr = cnt_m2_a;
                rd_nxt    = cnt_m2_a - AW'(1);
                wr_nxt    = cnt_m1_a;
                rem_nxt   = CW'(lvl_w - LW'(2));
                held_nxt  = top_r;
                up_nxt    = 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_LOAD: begin
        top_nxt = mem_rdata;
        done    = 1'b1;
      end
      S_SWAP: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_m1_a;
        top_nxt   = mem_rdata;
        done      = 1'b1;
      end
      S_COPY: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_a;
        top_nxt   = mem_rdata;
        cnt_nxt   = cnt_r + CW'(1);
        done      = 1'b1;
      end
      S_HOLD: begin
        held_nxt = mem_rdata;
        rd_nxt   = rd_r + AW'(1);
      end
      S_MOVE: begin
        // write the word read last cycle, issue the next read
        mem_we = 1'b1;
        wr_nxt = up_r ? (wr_r + AW'(1)) : (wr_r - AW'(1));
        if (wr_r == cnt_m1_a) top_nxt = mem_rdata;
        if (rem_r != '0) begin
          rd_nxt  = up_r ? (rd_r + AW'(1)) : (rd_r - AW'(1));
          rem_nxt = rem_r - CW'(1);
        end
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_wdata = held_r;
        if (up_r) top_nxt = held_r;
        done      = 1'b1;
      end
      S_WAIT: begin
        done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      top_r       <= '0;
      stat_r      <= ST_DONE;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      top_r  <= top_nxt;
      stat_r <= stat_nxt;
      if (done && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    rd_r   <= rd_nxt;
    wr_r   <= wr_nxt;
    rem_r  <= rem_nxt;
    up_r   <= up_nxt;
    if (done && slot_free) begin
      out_top_r  <= VAL_W'(top_nxt);
      out_cnt_r  <= CNT_OUT_W'(cnt_nxt);
      out_stat_r <= stat_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && op == OP_PUSH && !full) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("accepted push did not bump the count");

  a_write_live: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (CW'(mem_waddr) < cnt_nxt))
    else $error("cell write above the stack top");

  a_roll_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_HOLD || st_r == S_MOVE) |=> $stable(cnt_r))
    else $error("count changed during roll");

endmodule

`default_nettype wire

>>> tb/rpn_data_stack_test.sv
// Self-checking testbench for the RPN data stack: random stack ops, scoreboard predictor.
`timescale 1ns / 100ps

module rpn_data_stack_test;
  import rds_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0]     top_word;
    logic [CNT_OUT_W-1:0] entry_count;
    stat_t                status;
  } stack_view_t;

  typedef enum int {FILL_UP, DRAIN_DOWN, CHURN} op_mix_t;

  // Mirrors the stack contents and queues the view expected after each op.
  class stack_tracker;
    logic [VAL_W-1:0] cells [DEPTH_DEF];
    int unsigned      depth_used;
    stack_view_t      pending [$];
    int               mismatches;

    function new();
      depth_used = 0;
      mismatches = 0;
    endfunction

    function stat_t copy_from(int unsigned lvl);
      if (lvl < 1 || lvl > depth_used) return ST_IGNORED;
      if (depth_used >= DEPTH_DEF) return ST_OVERFLOW;
      cells[depth_used] = cells[depth_used - lvl];
      depth_used++;
      return ST_DONE;
    endfunction

    function stat_t rotate(int unsigned lvl, bit down);
      int               base;
      logic [VAL_W-1:0] held;
      if (lvl < 1 || lvl > depth_used) return ST_IGNORED;
      base = depth_used - lvl;
      if (!down) begin
        held = cells[base];
        for (int k = base; k < int'(depth_used) - 1; k++) cells[k] = cells[k + 1];
        cells[depth_used - 1] = held;
      end else begin
        held = cells[depth_used - 1];
        for (int k = depth_used - 1; k > base; k--) cells[k] = cells[k - 1];
        cells[base] = held;
      end
      return ST_DONE;
    endfunction

    function void apply_op(op_t op, logic [VAL_W-1:0] value, logic [LVL_W-1:0] lvl);
      stat_t            st;
      stack_view_t      view;
      logic [VAL_W-1:0] tmp;
      st = ST_DONE;
      case (op)
        OP_PUSH: begin
          if (depth_used >= DEPTH_DEF) st = ST_OVERFLOW;
          else begin
            cells[depth_used] = value;
            depth_used++;
          end
        end
        OP_DROP: begin
          if (depth_used == 0) st = ST_IGNORED;
          else depth_used--;
        end
        OP_DUP:  st = copy_from(1);
        OP_SWAP: begin
          if (depth_used < PAIR_NEEDED) st = ST_IGNORED;
          else begin
            tmp = cells[depth_used - 1];
            cells[depth_used - 1] = cells[depth_used - 2];
            cells[depth_used - 2] = tmp;
          end
        end
        OP_OVER: st = copy_from(PAIR_NEEDED);
        OP_PICK: st = copy_from(lvl);
        OP_ROLL: st = rotate(lvl, 1'b0);
        default: st = rotate(lvl, 1'b1);
      endcase
      view.top_word    = (depth_used == 0) ? '0 : cells[depth_used - 1];
      view.entry_count = depth_used[CNT_OUT_W-1:0];
      view.status      = st;
      pending = {pending, view};
    endfunction

    function void check_result(logic [VAL_W-1:0] top, logic [CNT_OUT_W-1:0] cnt,
                               logic [STAT_W-1:0] st);
      stack_view_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word: top %h count %0d status %0d", $time, top, cnt, st);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (top !== want.top_word) begin
        $display("%0t: top word expected %h, got %h", $time, want.top_word, top);
        mismatches++;
      end
      if (cnt !== want.entry_count) begin
        $display("%0t: entry count expected %0d, got %0d", $time, want.entry_count, cnt);
        mismatches++;
      end
      if (st !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, st);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [OP_W-1:0]      in_operation;
  logic [VAL_W-1:0]     in_push_value;
  logic [LVL_W-1:0]     in_level;
  logic                 out_valid;
  logic                 out_ready;
  logic [VAL_W-1:0]     out_top_word;
  logic [CNT_OUT_W-1:0] out_entry_count;
  logic [STAT_W-1:0]    out_status;

  stack_tracker tracker = new();
  bit           gaps_on = 1'b1;
  bit           hold_request = 1'b0;

  rpn_data_stack u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_push_value   (in_push_value),
    .in_level        (in_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_top_word    (out_top_word),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [LVL_W-1:0] pick_level();
    int r;
    int n;
    n = tracker.depth_used;
    r = $urandom_range(0, 99);
    if (r < 80 && n > 0) return LVL_W'($urandom_range(1, n));
    if (r < 87) return '0;
    if (r < 94) return LVL_W'(n + 1);
    return LVL_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return $urandom;
  endfunction

  // Called at a falling edge; returns at a falling edge after the word is taken.
  task automatic send_word(op_t op, logic [VAL_W-1:0] value, logic [LVL_W-1:0] lvl);
    int gap;
    in_operation  <= op;
    in_push_value <= value;
    in_level      <= lvl;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending.size() != 0) @(negedge clk);
  endtask

  // Scoreboard taps; input first so a same-cycle result finds its expectation.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      tracker.apply_op(op_t'(in_operation), in_push_value, in_level);
    if (rst_n && out_valid && out_ready)
      tracker.check_result(out_top_word, out_entry_count, out_status);
  end

  initial begin : result_sink
    int quiet;
    quiet = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (90) @(negedge clk);
        hold_request <= 1'b0;
      end else if (quiet > 0) begin
        out_ready <= 1'b0;
        quiet--;
      end else begin
        out_ready <= 1'b1;
        if (gaps_on && $urandom_range(0, 3) == 0) quiet = pick_gap();
      end
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    op_mix_t mix;
    int      r;
    int      push_pct;
    int      drop_pct;
    op_t     op;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = OP_PUSH;
    in_push_value = '0;
    in_level      = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty and small-stack corner cases
    send_word(OP_DROP, '0, '0);
    send_word(OP_DUP, '0, '0);
    send_word(OP_ROLL, '0, 5'd1);
    send_word(OP_PUSH, 32'hFFFF_FFFF, '0);
    send_word(OP_SWAP, '0, '0);
    send_word(OP_OVER, '0, '0);
    send_word(OP_ROLL, '0, 5'd1);
    send_word(OP_ROLL_DOWN, '0, 5'd1);
    send_word(OP_PUSH, 32'h0000_0000, '0);
    send_word(OP_SWAP, '0, '0);
    send_word(OP_OVER, '0, '0);
    send_word(OP_DUP, '0, '0);
    send_word(OP_PICK, '0, 5'd0);
    send_word(OP_PICK, '0, 5'd5);
    send_word(OP_PICK, '0, 5'd3);
    send_word(OP_ROLL, '0, 5'd5);
    send_word(OP_ROLL_DOWN, '0, 5'd4);
    send_word(OP_ROLL_DOWN, '0, 5'd31);
    // Fill to the top, then the full-stack cases
    while (tracker.depth_used < DEPTH_DEF) send_word(OP_PUSH, $urandom, '0);
    send_word(OP_PUSH, 32'h8000_0001, '0);
    send_word(OP_DUP, '0, '0);
    send_word(OP_OVER, '0, '0);
    send_word(OP_PICK, '0, 5'd16);
    send_word(OP_ROLL, '0, 5'd16);
    send_word(OP_ROLL_DOWN, '0, 5'd16);
    send_word(OP_PICK, '0, 5'd17);

    mix = CHURN;
    for (int i = 0; i < 1000; i++) begin
      if (i % 100 == 0) begin
        r = $urandom_range(0, 2);
        mix = op_mix_t'(r);
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      if (i == 300) begin
        // Receiver stalls long while words keep coming
        hold_request <= 1'b1;
        gaps_on = 1'b0;
      end
      if (i == 330) gaps_on = 1'b1;
      if (i == 600) wait_drained();
      case (mix)
        FILL_UP:    begin push_pct = 60; drop_pct = 5;  end
        DRAIN_DOWN: begin push_pct = 10; drop_pct = 50; end
        default:    begin push_pct = 25; drop_pct = 15; end
      endcase
      r = $urandom_range(0, 99);
      if (r < push_pct) op = OP_PUSH;
      else if (r < push_pct + drop_pct) op = OP_DROP;
      else op = op_t'($urandom_range(OP_DUP, OP_ROLL_DOWN));
      send_word(op, pick_value(), pick_level());
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (tracker.mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
